### rtl/sinosc_pkg.sv
package sinosc_pkg;

	// field widths
	localparam int FREQ_W   = 24;
	localparam int AMP_W    = 16;
	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 32;

	// shared multiplier, unsigned operands
	localparam int MUL_W  = 25;
	localparam int PROD_W = 2 * MUL_W;

	// quarter-wave polynomial, unsigned q16
	localparam logic [16:0] POLY_A = 17'd102944;
	localparam logic [15:0] POLY_B = 16'd42048;
	localparam logic [12:0] POLY_C = 13'd4640;
	localparam logic [16:0] ONE_Q16 = 17'h10000;
	localparam logic [14:0] SAT_Q15 = 15'h7fff;
	localparam logic [14:0] HALF_Q15 = 15'h4000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FR,
		ST_FQ,
		ST_PL,
		ST_PH,
		ST_QSR,
		ST_PHASE,
		ST_U2,
		ST_T1,
		ST_T2,
		ST_Y,
		ST_MAG
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_FR,
		OP_FQ,
		OP_PL,
		OP_PH,
		OP_QSR,
		OP_PHASE,
		OP_U2,
		OP_T1,
		OP_T2,
		OP_Y,
		OP_MAG
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

### rtl/sinosc_in_if.sv
interface sinosc_in_if import sinosc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [FREQ_W-1:0] frequency_hz;
	logic signed [AMP_W-1:0]  amplitude;

	modport source (output valid, output frequency_hz, output amplitude, input ready);
	modport sink (input valid, input frequency_hz, input amplitude, output ready);
endinterface

### rtl/sinosc_out_if.sv
interface sinosc_out_if import sinosc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [PHASE_W-1:0]         phase_out;

	modport source (output valid, output sample, output phase_out, input ready);
	modport sink (input valid, input sample, input phase_out, output ready);
endinterface

### rtl/sine_oscillator_phase_accum_top.sv
// channel | dir | handshake     | word
// tone    | in  | valid / ready | frequency_hz (s24 q16.8), amplitude (s16 q1.15)
// wave    | out | valid / ready | sample (s16 q1.15), phase_out (u32, 2^32 = one turn)
//
// one word in work at a time: an accept and eleven steps, ten of them through the
// single shared 25x25 multiplier (increment, quarter-wave polynomial, amplitude) and
// one phase update
// a result shows after its word runs fr, fq, pl, ph, qsr, phase, u2, t1, t2, y, mag
// the output register lets the next word be accepted while a result waits
// a stalled result holds the last step until the output register frees up
// arst_n clears the phase accumulator and the output valid
module sine_oscillator_phase_accum_top import sinosc_pkg::*; #(
	parameter int SAMPLE_RATE = 48000,
	parameter int TABLE_BITS  = 10
) (
	input logic          clk,
	input logic          arst_n,
	sinosc_in_if.sink    tone,
	sinosc_out_if.source wave
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	sinosc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tone_valid (tone.valid),
		.tone_ready (tone.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// arithmetic and result register
	sinosc_dp #(
		.SAMPLE_RATE (SAMPLE_RATE),
		.TABLE_BITS  (TABLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.frequency_hz (tone.frequency_hz),
		.amplitude    (tone.amplitude),
		.sample       (wave.sample),
		.phase_out    (wave.phase_out),
		.wave_valid   (wave.valid),
		.wave_ready   (wave.ready)
	);

endmodule

### rtl/sinosc_ctrl.sv
module sinosc_ctrl import sinosc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tone_valid,
	output logic     tone_ready,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	state_t state_q, state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// step sequence, at most one multiply per step
	always_comb begin
		state_next = state_q;
		cmd.op     = OP_NONE;
		tone_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				tone_ready = 1'b1;
				if (tone_valid) begin
					cmd.op     = OP_LOAD;
					state_next = ST_FR;
				end
			end
			ST_FR: begin
				cmd.op     = OP_FR;
				state_next = ST_FQ;
			end
			ST_FQ: begin
				cmd.op     = OP_FQ;
				state_next = ST_PL;
			end
			ST_PL: begin
				cmd.op     = OP_PL;
				state_next = ST_PH;
			end
			ST_PH: begin
				cmd.op     = OP_PH;
				state_next = ST_QSR;
			end
			ST_QSR: begin
				cmd.op     = OP_QSR;
				state_next = ST_PHASE;
			end
			ST_PHASE: begin
				cmd.op     = OP_PHASE;
				state_next = ST_U2;
			end
			ST_U2: begin
				cmd.op     = OP_U2;
				state_next = ST_T1;
			end
			ST_T1: begin
				cmd.op     = OP_T1;
				state_next = ST_T2;
			end
			ST_T2: begin
				cmd.op     = OP_T2;
				state_next = ST_Y;
			end
			ST_Y: begin
				cmd.op     = OP_Y;
				state_next = ST_MAG;
			end
			ST_MAG: begin
				// wait here while the previous word is still unclaimed
				if (!stat.out_busy) begin
					cmd.op     = OP_MAG;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/sinosc_dp.sv
module sinosc_dp import sinosc_pkg::*; #(
	parameter int SAMPLE_RATE = 48000,
	parameter int TABLE_BITS  = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	input  logic signed [FREQ_W-1:0]   frequency_hz,
	input  logic signed [AMP_W-1:0]    amplitude,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [PHASE_W-1:0]         phase_out,
	output logic                       wave_valid,
	input  logic                       wave_ready
);

	// increment = f*Q + floor((f*R + SR/2) / SR), with 2^24 = Q*SR + R
	localparam int R_W = $clog2(SAMPLE_RATE + 1);
	localparam int X_W = 24 + R_W;
	localparam longint unsigned TURN_Q24 = 64'd1 << 24;
	localparam logic [R_W-1:0] SR_C = R_W'(SAMPLE_RATE);
	localparam logic [R_W-1:0] R_C = R_W'(TURN_Q24 % 64'(SAMPLE_RATE));
	localparam logic [R_W-1:0] H_C = R_W'(SAMPLE_RATE / 2);
	localparam logic [MUL_W-1:0] Q_C = MUL_W'(TURN_Q24 / 64'(SAMPLE_RATE));
	// reciprocal, 2^X_W / SR, held below 2^25 (a power of two rate reaches it)
	// the quotient estimate stays within one below the true value either way
	localparam longint unsigned M_FULL = (64'd1 << X_W) / 64'(SAMPLE_RATE);
	localparam logic [MUL_W-1:0] M_C = (M_FULL >= (64'd1 << MUL_W)) ? '1 : MUL_W'(M_FULL);
	// table index bits below the quadrant, placed in q16
	localparam int X_SHIFT = 18 - TABLE_BITS;
	localparam logic [15:0] X_MASK = 16'(ONE_Q16 - (17'd1 << X_SHIFT));

	logic [FREQ_W-2:0]      f_q;
	logic [AMP_W-2:0]       a_q;
	logic [X_W-1:0]         x_q;
	logic [PHASE_W-1:0]     fq_q;
	logic [MUL_W-1:0]       pl_q;
	logic [23:0]            qa_q;
	logic [X_W-1:0]         qsr_q;
	logic [PHASE_W-1:0]     phase_q;
	logic [16:0]            u2_q;
	logic [15:0]            t1_q;
	logic [16:0]            t2_q;
	logic [14:0]            ys_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [PHASE_W-1:0]     phase_out_q;
	logic                   out_valid_q;

	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	logic [15:0]       x16;
	logic [16:0]       u;
	logic [R_W+25:0]   qa_sum;
	logic [X_W-1:0]    rem;
	logic              corr;
	logic [PHASE_W-1:0] inc;
	logic [17:0]       y_rnd;
	logic [16:0]       y_half;
	logic [14:0]       ys_next;
	logic [29:0]       mag_sum;
	logic [14:0]       mag;

	// quarter-wave argument from the current phase
	always_comb begin
		x16 = phase_q[29:14] & X_MASK;
		u   = phase_q[30] ? (ONE_Q16 - {1'b0, x16}) : {1'b0, x16};
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_FR: begin
				mul_a = MUL_W'(f_q);
				mul_b = MUL_W'(R_C);
			end
			OP_FQ: begin
				mul_a = MUL_W'(f_q);
				mul_b = Q_C;
			end
			OP_PL: begin
				mul_a = MUL_W'(x_q[23:0]);
				mul_b = M_C;
			end
			OP_PH: begin
				mul_a = MUL_W'(x_q[X_W-1:24]);
				mul_b = M_C;
			end
			OP_QSR: begin
				mul_a = MUL_W'(qa_q);
				mul_b = MUL_W'(SR_C);
			end
			OP_U2: begin
				mul_a = MUL_W'(u);
				mul_b = MUL_W'(u);
			end
			OP_T1: begin
				mul_a = MUL_W'(POLY_C);
				mul_b = MUL_W'(u2_q);
			end
			OP_T2: begin
				mul_a = MUL_W'(t1_q);
				mul_b = MUL_W'(u2_q);
			end
			OP_Y: begin
				mul_a = MUL_W'(u);
				mul_b = MUL_W'(t2_q);
			end
			OP_MAG: begin
				mul_a = MUL_W'(ys_q);
				mul_b = MUL_W'(a_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	// post-multiply arithmetic
	always_comb begin
		qa_sum  = (R_W+26)'(prod[R_W+24:0]) + (R_W+26)'(pl_q);
		rem     = x_q - qsr_q;
		corr    = (rem >= X_W'(SR_C));
		inc     = fq_q + PHASE_W'(qa_q) + PHASE_W'(corr);
		y_rnd   = {1'b0, prod[32:16]} + 18'd1;
		y_half  = y_rnd[17:1];
		ys_next = (y_half > {2'b00, SAT_Q15}) ? SAT_Q15 : y_half[14:0];
		mag_sum = prod[29:0] + 30'(HALF_Q15);
		mag     = mag_sum[29:15];
	end

	// phase accumulator and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_PHASE) begin
				phase_q <= phase_q + inc;
			end
			if (cmd.op == OP_MAG) begin
				out_valid_q <= 1'b1;
			end else if (wave_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers, each written by a single step
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				f_q <= frequency_hz[FREQ_W-1] ? '0 : frequency_hz[FREQ_W-2:0];
				a_q <= amplitude[AMP_W-1] ? '0 : amplitude[AMP_W-2:0];
			end
			OP_FR:  x_q   <= X_W'(prod) + X_W'(H_C);
			OP_FQ:  fq_q  <= prod[PHASE_W-1:0];
			OP_PL:  pl_q  <= prod[48:24];
			OP_PH:  qa_q  <= qa_sum[R_W+23:R_W];
			OP_QSR: qsr_q <= prod[X_W-1:0];
			OP_U2:  u2_q  <= prod[32:16];
			OP_T1:  t1_q  <= POLY_B - prod[31:16];
			OP_T2:  t2_q  <= POLY_A - {1'b0, prod[31:16]};
			OP_Y:   ys_q  <= ys_next;
			OP_MAG: begin
				sample_q    <= phase_q[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
				phase_out_q <= phase_q;
			end
			default: begin
			end
		endcase
	end

	assign stat.out_busy = out_valid_q && !wave_ready;
	assign wave_valid    = out_valid_q;
	assign sample        = sample_q;
	assign phase_out     = phase_out_q;

endmodule

### rtl/sinosc_chk.sv
module sinosc_chk import sinosc_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       tone_valid,
	input logic                       tone_ready,
	input logic                       wave_valid,
	input logic                       wave_ready,
	input logic signed [SAMPLE_W-1:0] sample,
	input logic [PHASE_W-1:0]         phase_out
);

	// a waiting result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		wave_valid && !wave_ready |=> wave_valid)
		else $error("wave valid dropped while stalled");

	// a waiting result keeps its word
	assert property (@(posedge clk) disable iff (!arst_n)
		wave_valid && !wave_ready |=> $stable(sample) && $stable(phase_out))
		else $error("wave word changed while stalled");

	// one word in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && tone_ready |=> !tone_ready)
		else $error("tone ready right after an accept");

	// a new result only comes out of a busy block
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(wave_valid) |-> $past(!tone_ready))
		else $error("result appeared while idle");

	// no result directly after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && tone_ready && !wave_valid |=> !wave_valid)
		else $error("result too soon after accept");

endmodule

bind sine_oscillator_phase_accum_top sinosc_chk u_sinosc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.tone_valid (tone.valid),
	.tone_ready (tone.ready),
	.wave_valid (wave.valid),
	.wave_ready (wave.ready),
	.sample     (wave.sample),
	.phase_out  (wave.phase_out)
);

### test/sine_oscillator_phase_accum_top_tb.sv
`timescale 1ns / 100ps

module sine_oscillator_phase_accum_top_tb import sinosc_pkg::*; ();

	localparam int OSC_RATE      = 48000;
	localparam int OSC_TBL_BITS  = 10;
	localparam int RANDOM_WORDS  = 1850;
	localparam int HOLD_AT_WORD  = 400;
	localparam int HOLD_CYCLES   = 300;
	localparam int STEADY_FIRST  = 800;
	localparam int STEADY_LAST   = 1100;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [PHASE_W-1:0]         phase;
	} wave_word_t;

	typedef struct packed {
		logic signed [FREQ_W-1:0]   freq;
		logic signed [AMP_W-1:0]    amp;
		logic                       known;
		logic signed [SAMPLE_W-1:0] want_sample;
		logic [PHASE_W-1:0]         want_phase;
	} tone_row_t;

	// directed words: extremes, clamps, quarter turns, wrap past half rate
	localparam int TONE_ROWS = 21;
	localparam tone_row_t TONE_TABLE [TONE_ROWS] = '{
		'{24'sd0,        16'sd32767,  1'b1, 16'sd0,      32'h0000_0000},
		'{-24'sd8388608, 16'sd32767,  1'b1, 16'sd0,      32'h0000_0000},
		'{24'sd3072000,  16'sd32767,  1'b1, 16'sd32766,  32'h4000_0000},
		'{24'sd3072000,  16'sd32767,  1'b1, 16'sd0,      32'h8000_0000},
		'{24'sd3072000,  16'sd32767,  1'b1, -16'sd32766, 32'hc000_0000},
		'{24'sd3072000,  -16'sd32768, 1'b1, 16'sd0,      32'h0000_0000},
		'{24'sd3072000,  -16'sd1,     1'b1, 16'sd0,      32'h4000_0000},
		'{-24'sd1,       16'sd32767,  1'b1, 16'sd32766,  32'h4000_0000},
		'{-24'sd1,       16'sd0,      1'b1, 16'sd0,      32'h4000_0000},
		'{-24'sd1,       16'sd1,      1'b1, 16'sd1,      32'h4000_0000},
		'{24'sd8388607,  16'sd32767,  1'b0, 16'sd0,      32'h0},
		'{24'sd6144000,  16'sd32767,  1'b0, 16'sd0,      32'h0},
		'{24'sd6144001,  16'sd16384,  1'b0, 16'sd0,      32'h0},
		'{24'sd1,        16'sd32767,  1'b0, 16'sd0,      32'h0},
		'{24'sd256,      16'sd12345,  1'b0, 16'sd0,      32'h0},
		'{24'sd110000,   16'sd32767,  1'b0, 16'sd0,      32'h0},
		'{24'sd8388607,  -16'sd32768, 1'b0, 16'sd0,      32'h0},
		'{24'sh400000,   16'sh5555,   1'b0, 16'sd0,      32'h0},
		'{24'sh2aaaaa,   16'sh2aaa,   1'b0, 16'sd0,      32'h0},
		'{24'sd3,        16'sd32767,  1'b0, 16'sd0,      32'h0},
		'{-24'sd2,       16'sd32767,  1'b0, 16'sd0,      32'h0}
	};

	logic clk;
	logic arst_n;

	sinosc_in_if  tone_ch ();
	sinosc_out_if wave_ch ();

	sine_oscillator_phase_accum_top #(
		.SAMPLE_RATE(OSC_RATE),
		.TABLE_BITS (OSC_TBL_BITS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tone  (tone_ch),
		.wave  (wave_ch)
	);

	// phase accumulator of the predictor and the waves still owed
	logic [PHASE_W-1:0] osc_phase = '0;
	wave_word_t         pending_waves[$];
	int unsigned        wave_errors = 0;
	int unsigned        cycle_cnt = 0;
	int unsigned        sent_cnt = 0;
	int unsigned        burst_left = 0;
	bit                 hold_req = 1'b0;
	bit                 steady;
	logic               row_known;
	wave_word_t         row_want;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	assign steady = (sent_cnt >= STEADY_FIRST) && (sent_cnt < STEADY_LAST);

	// advance the phase by one word and form the sample it yields
	function automatic wave_word_t synth_wave_word(input logic signed [FREQ_W-1:0] f_in,
			input logic signed [AMP_W-1:0] a_in);
		logic [63:0] f, a, step, x, u, u2, t, y, mag;
		logic [OSC_TBL_BITS-1:0] k;
		logic [1:0] quad;
		wave_word_t w;
		f = f_in[FREQ_W-1] ? 64'd0 : {40'd0, f_in};
		a = a_in[AMP_W-1] ? 64'd0 : {48'd0, a_in};
		step = ((f << 24) + 64'(OSC_RATE / 2)) / 64'(OSC_RATE);
		osc_phase = osc_phase + step[31:0];
		k = osc_phase[PHASE_W-1 -: OSC_TBL_BITS];
		quad = k[OSC_TBL_BITS-1 -: 2];
		x = 64'(k[OSC_TBL_BITS-3:0]) << (16 - (OSC_TBL_BITS - 2));
		u = quad[0] ? 64'(ONE_Q16) - x : x;
		// quarter-wave polynomial, each product truncated to q16
		u2 = (u * u) >> 16;
		t = 64'(POLY_B) - ((64'(POLY_C) * u2) >> 16);
		t = 64'(POLY_A) - ((t * u2) >> 16);
		y = (u * t) >> 16;
		y = (y + 64'd1) >> 1;
		if (y > 64'(SAT_Q15))
			y = 64'(SAT_Q15);
		// scale magnitude by amplitude, round half up, then restore sign
		mag = (y * a + 64'(HALF_Q15)) >> 15;
		w.sample = quad[1] ? 16'(64'd0 - mag) : mag[15:0];
		w.phase = osc_phase;
		return w;
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		wave_errors++;
		if (wave_errors <= REPORT_MAX)
			$display("mismatch %s: got %0d (0x%h) want %0d (0x%h)",
				what, got, got, want, want);
	endtask

	// offer one word, wait for it to be taken, then maybe open a gap
	task automatic send_tone(input logic signed [FREQ_W-1:0] f, input logic signed [AMP_W-1:0] a,
			input logic known, input wave_word_t want);
		int unsigned gap;
		tone_ch.valid <= 1'b1;
		tone_ch.frequency_hz <= f;
		tone_ch.amplitude <= a;
		row_known <= known;
		row_want <= want;
		@(posedge clk);
		while (!tone_ch.ready) @(posedge clk);
		sent_cnt++;
		if (sent_cnt == HOLD_AT_WORD)
			hold_req = 1'b1;
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 13);
			if (gap != 0) begin
				tone_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// predict on every accepted word, check on every delivered one
	always @(posedge clk) begin
		wave_word_t want;
		if (arst_n) begin
			if (tone_ch.valid && tone_ch.ready) begin
				want = synth_wave_word(tone_ch.frequency_hz, tone_ch.amplitude);
				if (row_known)
					want = row_want;
				pending_waves.push_back(want);
			end
			if (wave_ch.valid && wave_ch.ready) begin
				if (pending_waves.size() == 0) begin
					note_mismatch("unexpected word, phase", wave_ch.phase_out, 0);
				end else begin
					want = pending_waves.pop_front();
					if (wave_ch.sample !== want.sample)
						note_mismatch("sample", wave_ch.sample, want.sample);
					if (wave_ch.phase_out !== want.phase)
						note_mismatch("phase_out", wave_ch.phase_out, want.phase);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("sine_oscillator_phase_accum_top_tb NOT OK");
			$finish;
		end
	end

	// receiver: rotating stall mask, always ready in the steady window, one long hold-off on request
	initial begin
		logic [15:0] stall_mask;
		int unsigned tick;
		wave_ch.ready = 1'b0;
		stall_mask = '1;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				wave_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (tick % 64 == 0) begin
					if ($urandom_range(0, 3) == 0)
						stall_mask = '1;
					else
						stall_mask = 16'($urandom()) | (16'h1 << $urandom_range(0, 15));
				end
				wave_ch.ready <= steady ? 1'b1 : stall_mask[tick % 16];
				tick++;
			end
		end
	end

	// sender: directed table, then random words
	initial begin
		logic signed [FREQ_W-1:0] f;
		logic signed [AMP_W-1:0] a;
		wave_word_t want;
		tone_ch.valid = 1'b0;
		tone_ch.frequency_hz = '0;
		tone_ch.amplitude = '0;
		row_known = 1'b0;
		row_want = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < TONE_ROWS; i++) begin
			want.sample = TONE_TABLE[i].want_sample;
			want.phase = TONE_TABLE[i].want_phase;
			send_tone(TONE_TABLE[i].freq, TONE_TABLE[i].amp, TONE_TABLE[i].known, want);
		end

		want = '0;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// mostly audio-band tones, some raw, negative, near or above half rate
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: f = FREQ_W'($urandom_range(0, 20000 * 256));
				6:                f = FREQ_W'($urandom());
				7:                f = FREQ_W'($urandom()) | 24'sh800000;
				8:                f = FREQ_W'($urandom_range(6144000 - 1000, 8388607));
				default:          f = FREQ_W'($urandom_range(0, 15));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: a = AMP_W'($urandom_range(0, 32767));
				7:                   a = AMP_W'($urandom());
				8:                   a = $urandom_range(0, 1) ? 16'sd32767 : 16'sd0;
				default:             a = AMP_W'($urandom()) | 16'sh8000;
			endcase
			send_tone(f, a, 1'b0, want);
		end
		tone_ch.valid <= 1'b0;

		// let the last accept reach the predictor before looking at what is owed
		@(posedge clk);
		while (pending_waves.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (wave_errors == 0 && pending_waves.size() == 0)
			$display("sine_oscillator_phase_accum_top_tb OK");
		else
			$display("sine_oscillator_phase_accum_top_tb NOT OK");
		$finish;
	end

endmodule
